>>> sv/pip_pkg.sv
// package for the point-in-polygon crossing test
// shared widths, queue entry type and the edge crossing function; no dependencies
`default_nettype none
package pip_pkg;
  localparam int MaxVertices = 64;
  localparam int CoordWidth  = 16;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CntW        = 7;
  localparam int OutCntW     = 6;
  localparam int DiffW       = CoordWidth + 1;
  localparam int ProdW       = 2 * DiffW;

  typedef enum logic [0:0] {
    KIND_VERTEX = 1'b0,
    KIND_POINT  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                  is_point;
    logic [IdxW-1:0]       idx;
    logic [CoordWidth-1:0] x;
    logic [CoordWidth-1:0] y;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } walk_state_t;

  // per-edge classification without the product check
  typedef struct packed {
    logic decided;
    logic crossed;
    logic [DiffW-1:0] dy;
    logic [DiffW-1:0] t;
    logic [DiffW-1:0] ry;
    logic [DiffW-1:0] d;
  } edge_pre_t;

  function automatic edge_pre_t edge_classify(
    input logic signed [CoordWidth-1:0] px, input logic signed [CoordWidth-1:0] py,
    input logic signed [CoordWidth-1:0] x1, input logic signed [CoordWidth-1:0] y1,
    input logic signed [CoordWidth-1:0] x2, input logic signed [CoordWidth-1:0] y2);
    edge_pre_t r;
    logic signed [DiffW-1:0] tx;
    logic signed [DiffW-1:0] dx;
    tx = DiffW'(px) - DiffW'(x1);
    dx = DiffW'(x2) - DiffW'(x1);
    r.dy = DiffW'(y2) - DiffW'(y1);
    r.ry = DiffW'(py) - DiffW'(y1);
    r.t  = tx[DiffW-1] ? -tx : tx;
    r.d  = dx[DiffW-1] ? -dx : dx;
    r.decided = 1'b1;
    r.crossed = 1'b0;
    if ((x1 < px && x2 < px) || (x1 > px && x2 > px)) begin
      r.crossed = 1'b0;
    end else if (y1 < py && y2 < py) begin
      r.crossed = 1'b0;
    end else if (y1 > py && y2 > py) begin
      r.crossed = 1'b1;
    end else if (x1 == x2) begin
      r.crossed = 1'b0;
    end else begin
      r.decided = 1'b0;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> sv/point_in_polygon_crossing_test.sv
// point item: the back end walks the polygon edges for it, n being vertex_count capped
// at 64, one edge per cycle from the vertex store read port; the walk is skipped when n is below two.
// A vertex item is written to the vertex store. Items are handled one at a time in the
// back end, so a point holds it for its walk (plus any wait on an unaccepted result)
// while the front keeps filling a two-entry queue. Synchronous active-high reset clears
// control, the queue and vertex_count; the vertex store is undefined until written.
// depends on pip_pkg, pip_front, pip_queue, pip_back
`default_nettype none
module point_in_polygon_crossing_test (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pip_pkg::CntW-1:0]       cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           kind,
  input  wire logic [pip_pkg::IdxW-1:0]       vertex_index,
  input  wire logic [pip_pkg::CoordWidth-1:0] coord_x,
  input  wire logic [pip_pkg::CoordWidth-1:0] coord_y,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                inside_res,
  output logic [pip_pkg::OutCntW-1:0]         crossing_count
);
  logic [pip_pkg::CntW-1:0] vertex_count;
  logic q_full, q_push, q_pop, q_not_empty;
  pip_pkg::cmd_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) vertex_count <= '0;
    else if (cfg_we) vertex_count <= cfg_wdata;
  end

  pip_front u_front (
    .valid(in_valid), .ready(in_ready), .kind(kind), .vertex_index(vertex_index),
    .coord_x(coord_x), .coord_y(coord_y), .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  pip_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .not_empty(q_not_empty)
  );

  pip_back u_back (
    .clk(clk), .rst(rst), .vcount(vertex_count), .q_not_empty(q_not_empty),
    .q_data(q_out), .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
    .inside_res(inside_res), .crossing_count(crossing_count)
  );
endmodule
`default_nettype wire

>>> sv/pip_queue.sv
// two-entry item queue between the front and back ends
// depends on pip_pkg
`default_nettype none
module pip_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pip_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output pip_pkg::cmd_t      pop_data,
  output logic               not_empty
);
  pip_pkg::cmd_t mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

>>> sv/pip_front.sv
// front end: accepts items, classifies them and pushes them into the queue
// depends on pip_pkg
`default_nettype none
module pip_front (
  input  wire logic                           valid,
  output logic                                ready,
  input  wire logic                           kind,
  input  wire logic [pip_pkg::IdxW-1:0]       vertex_index,
  input  wire logic [pip_pkg::CoordWidth-1:0] coord_x,
  input  wire logic [pip_pkg::CoordWidth-1:0] coord_y,
  input  wire logic                           q_full,
  output logic                                q_push,
  output pip_pkg::cmd_t                       q_data
);
  assign ready  = !q_full;
  assign q_push = valid && !q_full;
  always_comb begin
    q_data.is_point = kind == pip_pkg::KIND_POINT;
    q_data.idx      = vertex_index;
    q_data.x        = coord_x;
    q_data.y        = coord_y;
  end
endmodule
`default_nettype wire

>>> sv/pip_back.sv
// back end: vertex store, edge walk with a registered product check, result register
// depends on pip_pkg
`default_nettype none
module pip_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [pip_pkg::CntW-1:0]          vcount,
  input  wire logic                              q_not_empty,
  input  wire pip_pkg::cmd_t                     q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   inside_res,
  output logic [pip_pkg::OutCntW-1:0]            crossing_count
);
  localparam int IdxW = pip_pkg::IdxW;
  localparam int CW   = pip_pkg::CoordWidth;
  localparam int DW   = pip_pkg::DiffW;
  localparam int PW   = pip_pkg::ProdW;

  logic [CW-1:0] vx_mem [pip_pkg::MaxVertices];
  logic [CW-1:0] vy_mem [pip_pkg::MaxVertices];

  pip_pkg::walk_state_t state, state_next;
  logic [IdxW:0]     rd_idx, rd_idx_next;
  logic [IdxW:0]     edges_left, edges_left_next;
  logic [pip_pkg::CntW-1:0] n_sat;
  logic [CW-1:0]     rx, ry;
  logic [CW-1:0]     prev_x, prev_y;
  logic              have_prev, have_prev_next;
  logic              rd_valid, rd_valid_next;
  logic              s2_valid;
  logic              s2_decided, s2_crossed;
  logic signed [PW-1:0] s2_lhs, s2_rhs;
  logic [IdxW:0]     count, count_next;
  logic              out_load;
  pip_pkg::edge_pre_t pre;

  assign n_sat = (vcount > pip_pkg::CntW'(pip_pkg::MaxVertices))
               ? pip_pkg::CntW'(pip_pkg::MaxVertices) : vcount;

  // read address is the next index so rx lines up with rd_idx and rd_valid
  always_ff @(posedge clk) begin
    if (q_pop && !q_data.is_point) begin
      vx_mem[q_data.idx] <= q_data.x;
      vy_mem[q_data.idx] <= q_data.y;
    end
    rx <= vx_mem[rd_idx_next[IdxW-1:0]];
    ry <= vy_mem[rd_idx_next[IdxW-1:0]];
  end

  // stage 1 classifies the edge formed by the previous and newly read vertex
  always_comb begin
    pre = pip_pkg::edge_classify(q_data.x, q_data.y, prev_x, prev_y, rx, ry);
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prev_x <= rx;
      prev_y <= ry;
    end
    s2_decided <= pre.decided;
    s2_crossed <= pre.crossed;
    s2_lhs <= $signed(pre.dy) * $signed({1'b0, pre.t[DW-2:0]});
    s2_rhs <= $signed(pre.ry) * $signed({1'b0, pre.d[DW-2:0]});
  end

  always_comb begin
    state_next      = state;
    rd_idx_next     = rd_idx;
    edges_left_next = edges_left;
    have_prev_next  = have_prev;
    rd_valid_next   = 1'b0;
    count_next      = count;
    q_pop           = 1'b0;
    out_load        = 1'b0;
    if (s2_valid) begin
      if (s2_decided ? s2_crossed : (s2_lhs >= s2_rhs)) count_next = count + 1'b1;
    end
    case (state)
      pip_pkg::ST_IDLE: begin
        if (q_not_empty) begin
          if (!q_data.is_point) begin
            q_pop = 1'b1;
          end else if (!out_valid || out_ready) begin
            count_next = '0;
            if (n_sat < 2) begin
              state_next = pip_pkg::ST_DONE;
            end else begin
              rd_idx_next     = '0;
              edges_left_next = (IdxW+1)'(n_sat - 1'b1);
              have_prev_next  = 1'b0;
              rd_valid_next   = 1'b1;
              state_next      = pip_pkg::ST_WALK;
            end
          end
        end
      end
      pip_pkg::ST_WALK: begin
        if (rd_valid) have_prev_next = 1'b1;
        if (rd_valid && have_prev) edges_left_next = edges_left - 1'b1;
        if (rd_valid && have_prev && edges_left == 1) begin
          state_next = pip_pkg::ST_DRAIN;
        end else if (rd_idx + 1'b1 < (IdxW+1)'(n_sat)) begin
          rd_idx_next   = rd_idx + 1'b1;
          rd_valid_next = 1'b1;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (!s2_valid) state_next = pip_pkg::ST_DONE;
      end
      pip_pkg::ST_DONE: begin
        // hold until the previous result item has left the output register
        if (!out_valid || out_ready) begin
          q_pop      = 1'b1;
          out_load   = 1'b1;
          state_next = pip_pkg::ST_IDLE;
        end
      end
      default: state_next = pip_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pip_pkg::ST_IDLE;
      rd_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      state     <= state_next;
      rd_valid  <= rd_valid_next;
      s2_valid  <= rd_valid && have_prev && state == pip_pkg::ST_WALK;
      have_prev <= have_prev_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    rd_idx     <= rd_idx_next;
    edges_left <= edges_left_next;
    count      <= count_next;
    if (out_load) begin
      inside_res     <= count[0];
      crossing_count <= count[pip_pkg::OutCntW-1:0];
    end
  end
endmodule
`default_nettype wire

>>> sv/pip_checker.sv
// port-level checks for point_in_polygon_crossing_test, bound to the top level
// depends on pip_pkg
`default_nettype none
module pip_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           inside_res,
  input wire logic [pip_pkg::OutCntW-1:0]    crossing_count
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(crossing_count) && $stable(inside_res))
    else $error("result item changed while stalled");
  a_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inside_res == crossing_count[0])
    else $error("parity disagrees with count");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn while stalled");
endmodule
bind point_in_polygon_crossing_test pip_checker u_pip_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .inside_res(inside_res), .crossing_count(crossing_count)
);
`default_nettype wire
